// ===== hdl/plb_pkg.sv =====
package plb_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // shift command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } t_shift_ctrl;

endpackage

// ===== hdl/plb_if.sv =====
interface plb_in_if #(
    parameter int POS_W = 5
);
    logic                               valid;
    logic                               ready;
    logic [plb_pkg::KIND_W-1:0]         kind;
    logic [POS_W-1:0]                   position;
    logic signed [plb_pkg::DATA_W-1:0]  value;

    modport source (output valid, kind, position, value, input ready);
    modport sink   (input valid, kind, position, value, output ready);
endinterface

interface plb_out_if #(
    parameter int POS_W = 5
);
    logic                               valid;
    logic                               ready;
    logic signed [plb_pkg::DATA_W-1:0]  data_out;
    logic [plb_pkg::STATUS_W-1:0]       status;
    logic [POS_W-1:0]                   entry_count;

    modport source (output valid, data_out, status, entry_count, input ready);
    modport sink   (input valid, data_out, status, entry_count, output ready);
endinterface

// ===== hdl/positional_list_buffer.sv =====
// Ordered list of signed 32-bit entries, up to CAPACITY deep, held in a row
// of cells, one entry per cell.
// Request channel (i_req): kind (insert, delete, read), position, value.
// Response channel (o_rsp): data_out, status, entry_count; one beat per
// request, in request order.
// Insert at p moves cells p and above up one place; delete at p moves cells
// above p down one place. All cells shift in parallel in the accept cycle.
// Latency: the response is registered and appears the cycle after accept.
// Throughput: one request per cycle unless a stalled response holds ready
// low; the cell-row shift and the one-hot read complete in the accept cycle.
// Stall: i_req.ready is high while the response register is empty or its
// beat is being taken, so a stalled receiver holds exactly one response and
// stops further requests until it drains.
// Reset: entry count goes to zero and the response register empties; cell
// contents are not cleared, only entries below the count are ever read.
module positional_list_buffer #(
    parameter int CAPACITY = plb_pkg::CAPACITY,
    parameter int POS_W    = $clog2(CAPACITY + 1)
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    plb_in_if.sink    i_req,
    plb_out_if.source o_rsp
);

    localparam logic [POS_W-1:0] CAP_CNT = POS_W'(CAPACITY);

    logic [POS_W-1:0]                   r_count;
    logic [POS_W-1:0]                   n_count;
    logic                               r_out_valid;
    logic signed [plb_pkg::DATA_W-1:0]  r_out_data;
    logic signed [plb_pkg::DATA_W-1:0]  n_out_data;
    logic [plb_pkg::STATUS_W-1:0]       r_out_status;
    logic [plb_pkg::STATUS_W-1:0]       n_out_status;

    logic                               w_accept;
    plb_pkg::t_shift_ctrl               w_ctrl;
    logic signed [plb_pkg::DATA_W-1:0]  w_cell_data [CAPACITY];
    logic [CAPACITY-1:0]                w_hit;
    logic signed [plb_pkg::DATA_W-1:0]  w_sel_data;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        plb_cell #(
            .IDX   (g),
            .POS_W (POS_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_pos   (i_req.position),
            .i_value (i_req.value),
            .i_below (w_cell_data[(g == 0) ? 0 : g - 1]),
            .i_above (w_cell_data[(g == CAPACITY - 1) ? g : g + 1]),
            .o_data  (w_cell_data[g]),
            .o_hit   (w_hit[g])
        );
    end

    // at most one cell matches the position
    always_comb begin
        w_sel_data = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (w_hit[k]) begin
                w_sel_data = w_sel_data | w_cell_data[k];
            end
        end
    end

    always_comb begin
        w_ctrl       = '0;
        n_count      = r_count;
        n_out_data   = '0;
        n_out_status = plb_pkg::ST_OK;
        unique case (i_req.kind)
            plb_pkg::KIND_INSERT: begin
                if (r_count >= CAP_CNT) begin
                    n_out_status = plb_pkg::ST_FULL;
                end else if (i_req.position > r_count) begin
                    n_out_status = plb_pkg::ST_INVALID;
                end else begin
                    w_ctrl.ins = w_accept;
                    n_count    = r_count + POS_W'(1);
                end
            end
            plb_pkg::KIND_DELETE: begin
                if (i_req.position >= r_count) begin
                    n_out_status = plb_pkg::ST_INVALID;
                end else begin
                    w_ctrl.del = w_accept;
                    n_out_data = w_sel_data;
                    n_count    = r_count - POS_W'(1);
                end
            end
            plb_pkg::KIND_READ: begin
                if (i_req.position >= r_count) begin
                    n_out_status = plb_pkg::ST_INVALID;
                end else begin
                    n_out_data = w_sel_data;
                end
            end
            default: begin
                n_out_status = plb_pkg::ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data   <= n_out_data;
            r_out_status <= n_out_status;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.data_out    = r_out_data;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_count = r_count;

endmodule

// ===== hdl/plb_cell.sv =====
module plb_cell #(
    parameter int IDX   = 0,
    parameter int POS_W = 5
) (
    input  logic                              i_clk,
    input  plb_pkg::t_shift_ctrl              i_ctrl,
    input  logic [POS_W-1:0]                  i_pos,
    input  logic signed [plb_pkg::DATA_W-1:0] i_value,
    input  logic signed [plb_pkg::DATA_W-1:0] i_below,
    input  logic signed [plb_pkg::DATA_W-1:0] i_above,
    output logic signed [plb_pkg::DATA_W-1:0] o_data,
    output logic                              o_hit
);

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic signed [plb_pkg::DATA_W-1:0] r_data;
    logic signed [plb_pkg::DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins) begin
            if (MY_IDX == i_pos) begin
                n_data = i_value;
            end else if (MY_IDX > i_pos) begin
                n_data = i_below;
            end
        end else if (i_ctrl.del) begin
            if (MY_IDX >= i_pos) begin
                n_data = i_above;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_hit  = (MY_IDX == i_pos);

endmodule
